// ===== sv/c3fd_pkg.sv =====
// shared widths, types and crc remainder table for the crc-3 frame decoder
package c3fd_pkg;

   localparam int DATA_W    = 7;
   localparam int BYTE_W    = 8;
   localparam int END_BIT   = 7;
   localparam int FRAME_W   = 42;
   localparam int WORD_W    = 39;
   localparam int CRC_W     = 3;
   localparam int ID_W      = 7;
   localparam int PAYLOAD_W = 32;
   localparam int POLY_W    = 4;
   localparam int POLY_SEL  = 8;

   localparam logic [POLY_W-1:0] CRC_POLY_RESET = 4'd11;

   // captured frame: 39-bit word (id over payload) and the received crc
   typedef struct packed {
      logic [WORD_W-1:0] word;
      logic [CRC_W-1:0]  recv_crc;
   } frame_type;

   // one mask per crc bit: which word bits feed that remainder bit
   typedef logic [CRC_W-1:0][WORD_W-1:0] rem_mask_type;

   // remainder of each single-bit word, built by the 3-term recurrence
   // r[j] = p2*r[j-1] ^ p1*r[j-2] ^ p0*r[j-3]; the top poly bit never
   // reaches the low three bits, so only poly bits 2..0 select a row
   function automatic rem_mask_type rem_row(input logic [CRC_W-1:0] p);
      logic [CRC_W-1:0] r [WORD_W];
      rem_mask_type     m;
      for (int j = 0; j < WORD_W; j++) begin
         if (j < CRC_W) begin
            r[j] = CRC_W'(1) << j;
         end else begin
            r[j] = ({CRC_W{p[2]}} & r[j-1]) ^ ({CRC_W{p[1]}} & r[j-2])
                 ^ ({CRC_W{p[0]}} & r[j-3]);
         end
      end
      for (int b = 0; b < CRC_W; b++) begin
         for (int j = 0; j < WORD_W; j++) begin
            m[b][j] = r[j][b];
         end
      end
      return m;
   endfunction

   localparam rem_mask_type REM_TABLE [POLY_SEL] = '{
      rem_row(3'd0), rem_row(3'd1), rem_row(3'd2), rem_row(3'd3),
      rem_row(3'd4), rem_row(3'd5), rem_row(3'd6), rem_row(3'd7)
   };

endpackage

// ===== sv/c3fd_frame.sv =====
// byte shift register and frame capture stage
module c3fd_frame
   import c3fd_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_take,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic              drain,
   output logic              frame_valid,
   output frame_type         frame
);

   logic [FRAME_W-1:0] shift_ff, shift_in;
   logic [FRAME_W-1:0] shifted;
   logic               valid_ff, valid_in;
   frame_type          frame_ff, frame_in;
   logic               is_end;

   assign shifted = {shift_ff[FRAME_W-DATA_W-1:0], rx_byte[DATA_W-1:0]};
   assign is_end  = rx_byte[END_BIT];

   always_comb begin
      shift_in = shift_ff;
      frame_in = frame_ff;
      valid_in = drain ? 1'b0 : valid_ff;
      if (byte_take) begin
         if (is_end) begin
            // register keeps only the word once the crc bits are split off
            shift_in          = {{CRC_W{1'b0}}, shifted[FRAME_W-1:CRC_W]};
            frame_in.word     = shifted[FRAME_W-1:CRC_W];
            frame_in.recv_crc = shifted[CRC_W-1:0];
            valid_in          = 1'b1;
         end else begin
            shift_in = shifted;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         shift_ff <= shift_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign frame_valid = valid_ff;
   assign frame       = frame_ff;

endmodule

// ===== sv/c3fd_check.sv =====
// crc check and result register
module c3fd_check
   import c3fd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [POLY_W-1:0]    csr_crc_poly,
   input  logic                 frame_valid,
   input  frame_type            frame,
   output logic                 advance,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_status,
   output logic [ID_W-1:0]      rsp_frame_id,
   output logic [PAYLOAD_W-1:0] rsp_payload
);

   rem_mask_type          mask_ff, mask_in;
   logic                  valid_ff, valid_in;
   logic                  status_ff, status_in;
   logic [ID_W-1:0]       id_ff, id_in;
   logic [PAYLOAD_W-1:0]  payload_ff, payload_in;
   logic [CRC_W-1:0]      crc;
   logic                  poly_top_unused;

   // top poly bit does not change the low three remainder bits
   assign poly_top_unused = csr_crc_poly[POLY_W-1];

   assign mask_in = csr_write ? REM_TABLE[csr_crc_poly[CRC_W-1:0]] : mask_ff;
   assign advance = !valid_ff || !rsp_stall;

   always_comb begin
      for (int b = 0; b < CRC_W; b++) begin
         crc[b] = ^(frame.word & mask_ff[b]);
      end
   end

   always_comb begin
      valid_in   = advance ? frame_valid : valid_ff;
      status_in  = status_ff;
      id_in      = id_ff;
      payload_in = payload_ff;
      if (advance && frame_valid) begin
         status_in  = (crc != frame.recv_crc) | (poly_top_unused & 1'b0);
         id_in      = frame.word[WORD_W-1:PAYLOAD_W];
         payload_in = frame.word[PAYLOAD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff  <= REM_TABLE[CRC_POLY_RESET[CRC_W-1:0]];
         valid_ff <= 1'b0;
      end else begin
         mask_ff  <= mask_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      id_ff      <= id_in;
      payload_ff <= payload_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_status   = status_ff;
   assign rsp_frame_id = id_ff;
   assign rsp_payload  = payload_ff;

endmodule

// ===== sv/crc3_seven_bit_frame_decoder.sv =====
// top level of the crc-3 seven-bit serial frame decoder
// Accepts one received byte per clock (req_valid high, req_stall low). Bits 6..0 of each
// byte shift into a 42-bit frame register; a byte with bit 7 set ends the frame.
// At frame end the low 3 bits are the received crc and bits 41..3 form the
// 39-bit word (7-bit id over 32-bit payload), which also stays in the shift
// register as the base for the next frame. The word is checked against the
// crc-3 long division by csr_crc_poly (reset 11): the remainder per word bit
// comes from a constant table row picked when the polynomial is written, so
// the check is a single xor tree per crc bit. One response per frame:
// rsp_status 0 on match, 1 on mismatch, id and payload reported either way.
// Rate is one byte per cycle while req_stall is low; after the end byte is taken
// the response word passes the frame register, then the result register. req_stall rises
// only when a captured frame and an unread response are both held.
// csr writes are always ready and load the mask register; write them when idle.
module crc3_seven_bit_frame_decoder
   import c3fd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   // byte input
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_rx_byte,
   // response
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_status,
   output logic [ID_W-1:0]      rsp_frame_id,
   output logic [PAYLOAD_W-1:0] rsp_payload,
   // polynomial register write
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [POLY_W-1:0]    csr_crc_poly
);

   logic      byte_take;
   logic      advance;
   logic      frame_valid;
   frame_type frame;

   // capture stage can take a new frame unless it holds one that cannot move
   assign req_stall = frame_valid && !advance;
   assign byte_take = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   c3fd_frame u_frame (
      .clock       (clock),
      .reset       (reset),
      .byte_take   (byte_take),
      .rx_byte     (req_rx_byte),
      .drain       (advance),
      .frame_valid (frame_valid),
      .frame       (frame)
   );

   c3fd_check u_check (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_valid && csr_ready),
      .csr_crc_poly (csr_crc_poly),
      .frame_valid  (frame_valid),
      .frame        (frame),
      .advance      (advance),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_frame_id (rsp_frame_id),
      .rsp_payload  (rsp_payload)
   );

   // both stages full and output blocked: input must hold off
   a_full_backpressure: assert property (@(posedge clock) disable iff (reset)
      (frame_valid && rsp_valid && rsp_stall) |-> req_stall)
      else $error("byte taken while both stages are full");

   // a blocked captured frame is kept intact
   a_frame_held: assert property (@(posedge clock) disable iff (reset)
      (frame_valid && rsp_valid && rsp_stall) |=> (frame_valid && $stable(frame)))
      else $error("captured frame lost while blocked");

   // a captured frame that can move shows up as a response next cycle
   a_frame_to_rsp: assert property (@(posedge clock) disable iff (reset)
      (frame_valid && !(rsp_valid && rsp_stall)) |=> rsp_valid)
      else $error("captured frame did not reach the response register");

   // a taken response with nothing behind it leaves the output empty
   a_rsp_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !frame_valid) |=> !rsp_valid)
      else $error("response repeated");

endmodule
